/* src/mjf_pkg.sv */
package mjf_pkg;

  localparam int SLOTS_DEF     = 10;
  localparam int AVG_DEPTH_DEF = 8;
  localparam int CW            = 12;

  localparam logic [1:0] ACT_HEADER = 2'd0;
  localparam logic [1:0] ACT_RECORD = 2'd1;
  localparam logic [1:0] ACT_END    = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [2:0] K_SLOT  = 3'd0;
  localparam logic [2:0] K_TRACK = 3'd1;
  localparam logic [2:0] K_X     = 3'd2;
  localparam logic [2:0] K_Y     = 3'd3;
  localparam logic [2:0] K_KEY   = 3'd4;
  localparam logic [2:0] K_SYNC  = 3'd5;

  localparam logic [2:0] REG_DZ_LIMIT = 3'd0;
  localparam logic [2:0] REG_SHIFT_X  = 3'd1;
  localparam logic [2:0] REG_SHIFT_Y  = 3'd2;
  localparam logic [2:0] REG_MAX_X    = 3'd3;
  localparam logic [2:0] REG_MAX_Y    = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SLOT,
    ST_PREP,
    ST_SUM,
    ST_DIV,
    ST_EMIT_SLOT,
    ST_EMIT_TRACK,
    ST_EMIT_X,
    ST_EMIT_Y,
    ST_EMIT_LIFT,
    ST_EMIT_KEY,
    ST_EMIT_SYNC
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic ld_in;
    logic rec;
    logic hdr;
    logic slot_clr;
    logic slot_inc;
    logic prep;
    logic sum_step;
    logic div_start;
    logic commit;
    logic lift;
    logic key_upd;
    logic end_frame;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic present;
    logic was_active;
    logic last_slot;
    logic sum_done;
    logic div_done;
    logic key_change;
    logic avg_path;
  } stat_t;

endpackage

/* src/mjf_datapath.sv */
module mjf_datapath #(
  parameter int SLOTS     = mjf_pkg::SLOTS_DEF,
  parameter int AVG_DEPTH = mjf_pkg::AVG_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mjf_pkg::cmd_t        cmd,
  output mjf_pkg::stat_t       stat,
  input  logic [1:0]           action,
  input  logic [7:0]           record_count,
  input  logic [31:0]          point_record,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [11:0]          cfg_data,
  input  logic [2:0]           ev_sel,
  output logic [16:0]          ev_value,
  output logic [1:0]           act
);
  import mjf_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PW = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int FW = $clog2(AVG_DEPTH + 1);
  localparam int RW = $clog2(SLOTS + 1);
  localparam int MD = SLOTS * AVG_DEPTH;
  localparam int MW = (MD > 1) ? $clog2(MD) : 1;
  localparam int AW = CW + FW;
  localparam int DW = $clog2(AW + 1);

  // config registers
  logic [11:0] dz_limit, shift_x, shift_y, max_x, max_y;
  always_ff @(posedge clk) begin
    if (rst) begin
      dz_limit <= 12'd8; shift_x <= '0; shift_y <= '0;
      max_x <= 12'd799; max_y <= 12'd479;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DZ_LIMIT: dz_limit <= cfg_data;
        REG_SHIFT_X:  shift_x  <= cfg_data;
        REG_SHIFT_Y:  shift_y  <= cfg_data;
        REG_MAX_X:    max_x    <= cfg_data;
        REG_MAX_Y:    max_y    <= cfg_data;
        default: ;
      endcase
    end
  end

  // input capture
  logic [7:0]  cnt_q;
  logic [31:0] rec_q;
  logic [1:0]  act_q;
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      cnt_q <= record_count; rec_q <= point_record; act_q <= action;
    end
  end
  assign act = act_q;

  logic [SLOTS-1:0] present, was_active;
  logic [CW-1:0] fpx [SLOTS], fpy [SLOTS];
  logic [CW-1:0] lrx [SLOTS], lry [SLOTS];
  logic [PW-1:0] rpos [SLOTS];
  logic [FW-1:0] rfill [SLOTS];
  logic [RW-1:0] records_left;
  logic [15:0] track_id;
  logic        any_q, was_any;
  logic [SW-1:0] slot;

  logic [3:0] rid;
  assign rid = rec_q[31:28];
  logic rec_ok;
  assign rec_ok = (rec_q[15:12] == 4'd0) && (rid >= 4'd1) && (32'(rid) <= SLOTS);
  logic [SW-1:0] rslot;
  assign rslot = SW'(rid - 4'd1);

  // frame capture
  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0; records_left <= '0;
    end else if (cmd.hdr) begin
      present <= '0;
      records_left <= (32'(cnt_q) > SLOTS) ? RW'(SLOTS) : RW'(cnt_q);
    end else if (cmd.rec && records_left != '0) begin
      records_left <= records_left - 1'b1;
      if (rec_ok) present[rslot] <= 1'b1;
    end else if (cmd.end_frame) begin
      records_left <= '0;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.rec && records_left != '0 && rec_ok) begin
      fpx[rslot] <= rec_q[11:0]; fpy[rslot] <= rec_q[27:16];
    end
  end

  // per-slot working values
  logic [CW-1:0] cx, cy, lx, ly;
  logic [PW-1:0] cp;
  logic [FW-1:0] cf;
  logic          jump;
  logic [CW:0] dx, dy;
  always_comb begin
    cx = fpx[slot]; cy = fpy[slot];
    if (was_active[slot]) begin
      lx = lrx[slot]; ly = lry[slot]; cp = rpos[slot]; cf = rfill[slot];
    end else begin
      lx = cx; ly = cy; cp = '0; cf = '0;
    end
    dx = (cx >= lx) ? {1'b0, cx - lx} : {1'b0, lx - cx};
    dy = (cy >= ly) ? {1'b0, cy - ly} : {1'b0, ly - cy};
    jump = (dx > {1'b0, dz_limit}) || (dy > {1'b0, dz_limit});
  end

  logic          jump_q;
  logic [FW-1:0] fill_q;
  logic [PW-1:0] wpos_q;
  logic [CW-1:0] rx_q, ry_q;
  logic [FW-1:0] idx;
  logic [AW-1:0] sx, sy;
  logic [CW-1:0] mx, my;

  // ring memory
  logic [CW-1:0] ring_x [MD], ring_y [MD];
  logic [CW-1:0] rdx, rdy;
  logic [MW-1:0] rad;
  assign rad = MW'(32'(slot) * AVG_DEPTH + 32'(idx));
  logic rd_v;
  always_ff @(posedge clk) begin
    if (cmd.prep && !jump) begin
      ring_x[MW'(32'(slot) * AVG_DEPTH + 32'(cp))] <= cx;
      ring_y[MW'(32'(slot) * AVG_DEPTH + 32'(cp))] <= cy;
    end
    rdx <= ring_x[rad]; rdy <= ring_y[rad];
  end

  // ring update, sum loop
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
    end else begin
      rd_v <= cmd.sum_step && (idx < fill_q);
    end
    if (cmd.prep) begin
      jump_q <= jump; rx_q <= cx; ry_q <= cy;
      wpos_q <= cp;
      fill_q <= (32'(cf) < AVG_DEPTH) ? cf + 1'b1 : cf;
      idx <= '0; sx <= '0; sy <= '0;
    end else if (cmd.sum_step) begin
      if (idx < fill_q) idx <= idx + 1'b1;
      if (rd_v) begin
        sx <= sx + AW'(rdx); sy <= sy + AW'(rdy);
      end
    end
  end
  assign stat.sum_done = (idx >= fill_q) && !rd_v;
  assign stat.avg_path = !jump_q;

  // restoring divider, x and y together
  logic [AW-1:0] qx, qy, rmx, rmy;
  logic [DW-1:0] dcnt;
  logic [AW:0] tx, ty;
  always_comb begin
    tx = {rmx[AW-1:0], qx[AW-1]} - {{(AW+1-FW){1'b0}}, fill_q};
    ty = {rmy[AW-1:0], qy[AW-1]} - {{(AW+1-FW){1'b0}}, fill_q};
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (cmd.div_start) begin
      qx <= sx; qy <= sy; rmx <= '0; rmy <= '0;
      dcnt <= DW'(AW);
    end else if (dcnt != '0) begin
      dcnt <= dcnt - 1'b1;
      if (!tx[AW]) begin rmx <= tx[AW-1:0]; qx <= {qx[AW-2:0], 1'b1}; end
      else begin rmx <= {rmx[AW-2:0], qx[AW-1]}; qx <= {qx[AW-2:0], 1'b0}; end
      if (!ty[AW]) begin rmy <= ty[AW-1:0]; qy <= {qy[AW-2:0], 1'b1}; end
      else begin rmy <= {rmy[AW-2:0], qy[AW-1]}; qy <= {qy[AW-2:0], 1'b0}; end
    end
  end
  assign stat.div_done = (dcnt == '0) && !cmd.div_start;
  assign mx = jump_q ? rx_q : qx[CW-1:0];
  assign my = jump_q ? ry_q : qy[CW-1:0];

  // offset and clamp
  logic signed [CW+1:0] ox, oy;
  logic [CW-1:0] fx, fy;
  always_comb begin
    ox = $signed({2'b00, mx}) + $signed({{2{shift_x[11]}}, shift_x});
    oy = $signed({2'b00, my}) + $signed({{2{shift_y[11]}}, shift_y});
    fx = ox[CW+1] ? '0 : (ox[CW:0] > {1'b0, max_x}) ? max_x : ox[CW-1:0];
    fy = oy[CW+1] ? '0 : (oy[CW:0] > {1'b0, max_y}) ? max_y : oy[CW-1:0];
  end

  // slot walk and per-slot state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0; was_active <= '0; track_id <= 16'd1;
      any_q <= 1'b0; was_any <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        lrx[i] <= '0; lry[i] <= '0; rpos[i] <= '0; rfill[i] <= '0;
      end
    end else begin
      if (cmd.slot_clr) begin
        slot <= '0; any_q <= 1'b0;
      end else if (cmd.slot_inc) begin
        slot <= slot + 1'b1;
      end
      if (cmd.commit) begin
        any_q <= 1'b1;
        if (!was_active[slot]) track_id <= track_id + 1'b1;
        was_active[slot] <= 1'b1;
        lrx[slot] <= rx_q; lry[slot] <= ry_q;
        if (jump_q) begin
          rpos[slot] <= '0; rfill[slot] <= '0;
        end else begin
          rpos[slot] <= (32'(wpos_q) + 1 >= AVG_DEPTH) ? '0 : wpos_q + 1'b1;
          rfill[slot] <= fill_q;
        end
      end
      if (cmd.lift) begin
        was_active[slot] <= 1'b0; rpos[slot] <= '0; rfill[slot] <= '0;
      end
      if (cmd.key_upd) was_any <= any_q;
    end
  end

  assign stat.present    = present[slot];
  assign stat.was_active = was_active[slot];
  assign stat.last_slot  = (32'(slot) == SLOTS - 1);
  assign stat.key_change = (any_q != was_any);

  // event value select
  always_comb begin
    unique case (ev_sel)
      K_SLOT:  ev_value = 17'(slot);
      K_TRACK: ev_value = was_active[slot] ? 17'h1FFFF : {1'b0, track_id};
      K_X:     ev_value = 17'(fx);
      K_Y:     ev_value = 17'(fy);
      K_KEY:   ev_value = 17'(any_q);
      default: ev_value = '0;
    endcase
  end
endmodule

/* src/mjf_ctrl.sv */
module mjf_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     act,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [2:0]     ev_sel,
  output logic           last_event,
  output mjf_pkg::cmd_t  cmd,
  input  mjf_pkg::stat_t stat
);
  import mjf_pkg::*;

  state_t state, state_next;
  logic   busy, busy_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; busy <= 1'b0;
    end else begin
      state <= state_next; busy <= busy_next;
    end
  end

  logic go;
  assign go = out_valid && out_ready;

  // sequencing
  always_comb begin
    state_next = state; busy_next = busy; cmd = '0;
    in_ready = 1'b0; out_valid = 1'b0; ev_sel = K_SYNC; last_event = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (busy) begin
          busy_next = 1'b0;
          unique case (act)
            ACT_HEADER: cmd.hdr = 1'b1;
            ACT_RECORD: cmd.rec = 1'b1;
            ACT_END: begin
              cmd.end_frame = 1'b1; cmd.slot_clr = 1'b1; state_next = ST_SLOT;
            end
            default: ;
          endcase
        end else begin
          in_ready = 1'b1;
          if (in_valid) begin cmd.ld_in = 1'b1; busy_next = 1'b1; end
        end
      end
      ST_SLOT: begin
        if (stat.present) begin cmd.prep = 1'b1; state_next = ST_PREP; end
        else if (stat.was_active) state_next = ST_EMIT_LIFT;
        else if (stat.last_slot) state_next = ST_EMIT_KEY;
        else cmd.slot_inc = 1'b1;
      end
      ST_PREP: begin
        cmd.sum_step = 1'b1; state_next = ST_SUM;
      end
      ST_SUM: begin
        if (stat.sum_done || !stat.avg_path) begin
          cmd.div_start = 1'b1; state_next = ST_DIV;
        end else cmd.sum_step = 1'b1;
      end
      ST_DIV: if (stat.div_done) state_next = ST_EMIT_SLOT;
      ST_EMIT_SLOT: begin
        out_valid = 1'b1; ev_sel = K_SLOT;
        if (go) state_next = stat.was_active ? ST_EMIT_X : ST_EMIT_TRACK;
      end
      ST_EMIT_TRACK: begin
        out_valid = 1'b1; ev_sel = K_TRACK;
        if (go) begin
          if (stat.present) state_next = ST_EMIT_X;
          else begin
            // lift: the -1 beat closes the slot
            cmd.lift = 1'b1;
            if (stat.last_slot) state_next = ST_EMIT_KEY;
            else begin cmd.slot_inc = 1'b1; state_next = ST_SLOT; end
          end
        end
      end
      ST_EMIT_X: begin
        out_valid = 1'b1; ev_sel = K_X;
        if (go) state_next = ST_EMIT_Y;
      end
      ST_EMIT_Y: begin
        out_valid = 1'b1; ev_sel = K_Y;
        if (go) begin
          cmd.commit = 1'b1;
          if (stat.last_slot) state_next = ST_EMIT_KEY;
          else begin cmd.slot_inc = 1'b1; state_next = ST_SLOT; end
        end
      end
      ST_EMIT_LIFT: begin
        out_valid = 1'b1; ev_sel = K_SLOT;
        if (go) state_next = ST_EMIT_TRACK;
      end
      ST_EMIT_KEY: begin
        if (stat.key_change) begin
          out_valid = 1'b1; ev_sel = K_KEY;
          if (go) begin cmd.key_upd = 1'b1; state_next = ST_EMIT_SYNC; end
        end else state_next = ST_EMIT_SYNC;
      end
      ST_EMIT_SYNC: begin
        out_valid = 1'b1; ev_sel = K_SYNC; last_event = 1'b1;
        if (go) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) cmd.commit |-> stat.present);
  assert property (@(posedge clk) disable iff (rst) in_ready |-> !out_valid);
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_event) |-> (ev_sel == K_SYNC));
endmodule

/* src/multitouch_jitter_filter_unit.sv */
// multitouch jitter filter unit
// input channel (in_valid/in_ready) takes one beat per item: a frame header
// with record_count, a point record, or a frame end. header and record
// beats give no result. a frame end walks every slot in order: a touched
// slot runs ring summing (one ring memory read per cycle, cut short on a
// dead zone jump), then shared serial division, then its event beats. the
// event stream (out_valid/out_ready) ends with a sync beat with last_event
// high; the next input is taken only after that sync beat is delivered.
// a stalled receiver simply holds the current event beat in place. reset
// clears all control and per-slot tracking state at once; ring contents
// are not cleared, entries are written before they are read. config is
// written through cfg_we/cfg_index/cfg_data; the user must do so only
// while idle, which the block itself does not enforce.
module multitouch_jitter_filter_unit #(
  parameter int SLOTS     = mjf_pkg::SLOTS_DEF,
  parameter int AVG_DEPTH = mjf_pkg::AVG_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic [7:0]         record_count,
  input  logic [31:0]        point_record,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         event_kind,
  output logic signed [16:0] event_value,
  output logic               last_event,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [11:0]        cfg_data
);
  import mjf_pkg::*;

  cmd_t        cmd;
  stat_t       stat;
  logic [1:0]  act;
  logic [2:0]  ev_sel;
  logic [16:0] ev_value;

  mjf_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .act, .out_valid, .out_ready,
    .ev_sel, .last_event, .cmd, .stat
  );

  mjf_datapath #(.SLOTS(SLOTS), .AVG_DEPTH(AVG_DEPTH)) u_dp (
    .clk, .rst, .cmd, .stat, .action, .record_count, .point_record,
    .cfg_we, .cfg_index, .cfg_data, .ev_sel, .ev_value, .act
  );

  assign event_kind  = ev_sel;
  assign event_value = $signed(ev_value);
endmodule

/* dv/multitouch_jitter_filter_unit_tb.sv */
`timescale 1ns / 1ps

module multitouch_jitter_filter_unit_tb;
  import mjf_pkg::*;

  localparam int NSLOT = 10;
  localparam int DEPTH = 8;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [16:0] value;
    logic        last;
  } touch_event_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  action = ACT_HEADER;
  logic [7:0]  record_count = '0;
  logic [31:0] point_record = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  event_kind;
  logic signed [16:0] event_value;
  logic        last_event;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_DZ_LIMIT;
  logic [11:0] cfg_data = '0;

  multitouch_jitter_filter_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .record_count(record_count), .point_record(point_record),
    .out_valid(out_valid), .out_ready(out_ready),
    .event_kind(event_kind), .event_value(event_value), .last_event(last_event),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // filter shadow state
  logic [11:0] dz_r, offx_r, offy_r, maxx_r, maxy_r;
  logic        present_q [NSLOT];
  logic [11:0] posx_q [NSLOT], posy_q [NSLOT];
  int          left_q;
  logic        active_q [NSLOT];
  logic [11:0] rawx_q [NSLOT], rawy_q [NSLOT];
  logic [11:0] ringx_q [NSLOT][DEPTH], ringy_q [NSLOT][DEPTH];
  int          rpos_q [NSLOT], rfill_q [NSLOT];
  logic [15:0] track_id_q;
  logic        any_touch_q;

  touch_event_t pending_events[$];
  int  errors = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  quiet_cycles = 0;

  function automatic int clamp_coord(int v, logic [11:0] hi);
    if (v < 0) return 0;
    if (v > int'(hi)) return int'(hi);
    return v;
  endfunction

  function automatic void push_event(logic [2:0] k, int v, logic l);
    touch_event_t e;
    e.kind = k;
    e.value = v[16:0];
    e.last = l;
    pending_events.push_back(e);
  endfunction

  // dead zone check then moving average over the slot ring
  function automatic void smooth_slot(int s, output int fx, output int fy);
    int dx, dy, dz, p, sx, sy;
    logic [11:0] x, y;
    x = posx_q[s];
    y = posy_q[s];
    dx = int'(x) - int'(rawx_q[s]);
    dy = int'(y) - int'(rawy_q[s]);
    dz = int'(dz_r);
    rawx_q[s] = x;
    rawy_q[s] = y;
    if (dx > dz || dx < -dz || dy > dz || dy < -dz) begin
      rpos_q[s] = 0;
      rfill_q[s] = 0;
      fx = int'(x);
      fy = int'(y);
      return;
    end
    p = rpos_q[s];
    ringx_q[s][p] = x;
    ringy_q[s][p] = y;
    rpos_q[s] = (p + 1) % DEPTH;
    if (rfill_q[s] < DEPTH) rfill_q[s]++;
    sx = 0;
    sy = 0;
    for (int i = 0; i < rfill_q[s]; i++) begin
      sx += int'(ringx_q[s][i]);
      sy += int'(ringy_q[s][i]);
    end
    fx = sx / rfill_q[s];
    fy = sy / rfill_q[s];
  endfunction

  function automatic void predict_item(logic [1:0] a, logic [7:0] cnt, logic [31:0] r);
    int fx, fy;
    logic any;
    logic [3:0] id;
    if (a == ACT_HEADER) begin
      foreach (present_q[s]) present_q[s] = 1'b0;
      left_q = (cnt > NSLOT) ? NSLOT : cnt;
    end else if (a == ACT_RECORD) begin
      id = r[31:28];
      if (left_q == 0) return;
      left_q--;
      if (r[15:12] != 0) return;
      if (id < 1 || id > NSLOT) return;
      present_q[id-1] = 1'b1;
      posx_q[id-1] = r[11:0];
      posy_q[id-1] = r[27:16];
    end else if (a == ACT_END) begin
      any = 1'b0;
      left_q = 0;
      for (int s = 0; s < NSLOT; s++) begin
        if (present_q[s]) begin
          any = 1'b1;
          push_event(K_SLOT, s, 1'b0);
          if (!active_q[s]) begin
            rpos_q[s] = 0;
            rfill_q[s] = 0;
            rawx_q[s] = posx_q[s];
            rawy_q[s] = posy_q[s];
            push_event(K_TRACK, int'(track_id_q), 1'b0);
            track_id_q = track_id_q + 16'd1;
          end
          smooth_slot(s, fx, fy);
          push_event(K_X, clamp_coord(fx + int'($signed(offx_r)), maxx_r), 1'b0);
          push_event(K_Y, clamp_coord(fy + int'($signed(offy_r)), maxy_r), 1'b0);
        end else if (active_q[s]) begin
          rpos_q[s] = 0;
          rfill_q[s] = 0;
          push_event(K_SLOT, s, 1'b0);
          push_event(K_TRACK, -1, 1'b0);
        end
        active_q[s] = present_q[s];
      end
      if (any != any_touch_q) begin
        push_event(K_KEY, int'(any), 1'b0);
        any_touch_q = any;
      end
      push_event(K_SYNC, 0, 1'b1);
    end
  endfunction

  // send one beat and update the shadow model on acceptance
  // valid stays up until the next beat or an idle cycle drops it
  task automatic send_beat(logic [1:0] a, logic [7:0] cnt, logic [31:0] r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    action <= a;
    record_count <= cnt;
    point_record <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_item(a, cnt, r);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [11:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DZ_LIMIT: dz_r = val;
      REG_SHIFT_X:  offx_r = val;
      REG_SHIFT_Y:  offy_r = val;
      REG_MAX_X:    maxx_r = val;
      default:      maxy_r = val;
    endcase
  endtask

  function automatic logic [31:0] make_point(logic [3:0] id, logic [11:0] x, logic [11:0] y);
    return {id, y, 4'h0, x};
  endfunction

  // one frame with random fingers near their last position; about one record in 16 is random junk
  task automatic send_frame(int n, int jitter);
    logic [3:0] id;
    logic [11:0] x, y;
    send_beat(ACT_HEADER, n[7:0], $urandom);
    for (int i = 0; i < n && i < NSLOT + 2; i++) begin
      id = 4'($urandom_range(NSLOT, 1));
      x = 12'(posx_q[id-1] + $urandom_range(2 * jitter) - jitter);
      y = 12'(posy_q[id-1] + $urandom_range(2 * jitter) - jitter);
      if ($urandom_range(15) == 0) send_beat(ACT_RECORD, 8'($urandom), $urandom);
      else send_beat(ACT_RECORD, 8'($urandom), make_point(id, x, y));
    end
    send_beat(ACT_END, 8'($urandom), $urandom);
  endtask

  task automatic test_directed();
    send_beat(ACT_END, 8'h00, 32'h0);
    send_beat(ACT_HEADER, 8'hFF, 32'h0);
    send_beat(ACT_RECORD, 8'h00, make_point(4'd1, 12'h000, 12'h000));
    send_beat(ACT_RECORD, 8'hFF, make_point(4'd10, 12'hFFF, 12'hFFF));
    send_beat(ACT_RECORD, 8'h00, 32'h3000_F123);
    send_beat(ACT_RECORD, 8'h00, make_point(4'd0, 12'h100, 12'h100));
    send_beat(ACT_RECORD, 8'h00, make_point(4'd15, 12'h100, 12'h100));
    send_beat(ACT_END, 8'h00, 32'h0);
    // repeated frame end reprocesses the held frame
    send_beat(ACT_END, 8'h00, 32'hFFFF_FFFF);
    // excess records past the count are dropped
    send_beat(ACT_HEADER, 8'd1, 32'h0);
    send_beat(ACT_RECORD, 8'h00, make_point(4'd1, 12'h003, 12'h002));
    send_beat(ACT_RECORD, 8'h00, make_point(4'd5, 12'h050, 12'h050));
    send_beat(ACT_UNUSED, 8'hAA, 32'h5555_AAAA);
    send_beat(ACT_END, 8'h00, 32'h0);
    // empty frame lifts everything
    send_beat(ACT_HEADER, 8'd0, 32'h0);
    send_beat(ACT_END, 8'h00, 32'h0);
    wait_drained();
  endtask

  task automatic test_config_extremes();
    write_reg(REG_DZ_LIMIT, 12'hFFF);
    write_reg(REG_SHIFT_X, 12'h7FF);
    write_reg(REG_SHIFT_Y, 12'h800);
    write_reg(REG_MAX_X, 12'hFFF);
    write_reg(REG_MAX_Y, 12'h000);
    repeat (6) send_frame($urandom_range(12), 2048);
    wait_drained();
    write_reg(REG_DZ_LIMIT, 12'h000);
    write_reg(REG_SHIFT_X, 12'h800);
    write_reg(REG_SHIFT_Y, 12'h7FF);
    write_reg(REG_MAX_X, 12'h000);
    write_reg(REG_MAX_Y, 12'hFFF);
    repeat (6) send_frame($urandom_range(12), 3);
    wait_drained();
  endtask

  // random frames and stray random beats; each frame is header, records and end
  task automatic test_random_frames(int items);
    int sent;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(9) == 0) begin
        send_beat(2'($urandom), 8'($urandom), $urandom);
        sent++;
      end else begin
        int n;
        n = $urandom_range(12);
        send_frame(n, ($urandom_range(3) == 0) ? 600 : 6);
        sent += n + 2;
      end
    end
    wait_drained();
  endtask

  task automatic randomize_config();
    write_reg(REG_DZ_LIMIT, 12'($urandom_range(40)));
    write_reg(REG_SHIFT_X, 12'($urandom));
    write_reg(REG_SHIFT_Y, 12'($urandom));
    write_reg(REG_MAX_X, 12'($urandom_range(4095, 400)));
    write_reg(REG_MAX_Y, 12'($urandom_range(4095, 300)));
  endtask

  // tracking ids keep counting across frames; a full 16-bit wrap is out of reach
  task automatic test_track_wrap();
    send_frame(4, 5);
    wait_drained();
  endtask

  // event checker
  always @(posedge clk) begin
    touch_event_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event kind %0d value %0d", $time, event_kind, event_value);
        errors++;
      end else begin
        e = pending_events.pop_front();
        if (e.kind !== event_kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, e.kind, event_kind);
          errors++;
        end
        if (e.value !== event_value) begin
          $display("%0t: value expected %0d actual %0d", $time,
                   $signed(e.value), event_value);
          errors++;
        end
        if (e.last !== last_event) begin
          $display("%0t: last expected %0d actual %0d", $time, e.last, last_event);
          errors++;
        end
      end
    end
  end

  // receiver backpressure
  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  // watchdog on handshake silence
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    dz_r = 12'd8; offx_r = '0; offy_r = '0; maxx_r = 12'd799; maxy_r = 12'd479;
    left_q = 0; track_id_q = 16'd1; any_touch_q = 1'b0;
    for (int s = 0; s < NSLOT; s++) begin
      present_q[s] = 0; active_q[s] = 0; rawx_q[s] = 0; rawy_q[s] = 0;
      posx_q[s] = 12'($urandom); posy_q[s] = 12'($urandom);
      rpos_q[s] = 0; rfill_q[s] = 0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 14; recv_idle_pct = 80;
    test_directed();
    test_config_extremes();
    randomize_config();
    test_random_frames(120);
    send_idle_pct = 80; recv_idle_pct = 14;
    randomize_config();
    test_random_frames(120);
    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(REG_DZ_LIMIT, 12'd8);
    write_reg(REG_SHIFT_X, 12'd0);
    write_reg(REG_SHIFT_Y, 12'd0);
    write_reg(REG_MAX_X, 12'd799);
    write_reg(REG_MAX_Y, 12'd479);
    test_random_frames(120);
    test_track_wrap();
    if (errors == 0 && pending_events.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
